// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bin block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the cycle after ante; skip while reset is high.
`define PLFB_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plfb check failed: next-cycle rule");

// Check cons in the same cycle as ante; no reset gating.
`define PLFB_ASSERT_SAME(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("plfb check failed: same-cycle rule");

`endif

// File: hw/rtl/plfb_pkg.sv
// ----------------------------------------------------------------------------
// plfb_pkg
// Widths and payload types of the piecewise-linear Fourier bin block.
// ----------------------------------------------------------------------------
package plfb_pkg;

  localparam int SAMPLE_W = 24;
  localparam int SUM_W    = 48;
  localparam int COEF_W   = 40;   // segment coefficients, Q40

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // One table row: weights of the newer (k1) and older (k0) sample.
  typedef struct packed {
    coef_t re_k1;
    coef_t re_k0;
    coef_t im_k1;
    coef_t im_k0;
  } coef_set_t;

endpackage

// File: hw/rtl/plfb_stream_if.sv
// ----------------------------------------------------------------------------
// plfb stream interfaces
// Valid/ready channels for sample words in and coefficient words out.
// ----------------------------------------------------------------------------
interface plfb_in_if import plfb_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface plfb_out_if import plfb_pkg::*; ();
  logic valid;
  logic ready;
  sum_t coef_real;
  sum_t coef_imag;

  modport source (output valid, output coef_real, output coef_imag, input ready);
  modport sink (input valid, input coef_real, input coef_imag, output ready);
endinterface

// File: hw/rtl/piecewise_linear_fourier_bin_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_fourier_bin_top
// Single-bin Fourier coefficient of a piecewise-linear sampled signal.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch (sink) takes one word per sample: a Q1.23 sample and a flag
//   that marks the last sample of a sequence. coef_ch (source) gives one word
//   per sequence: the real and imaginary sums, Q.23, saturated to 48 bits.
//   Each pair of neighboring samples adds the exact integral of the line
//   between them against cos + i sin at the fundamental; the phase wraps
//   every SAMPLES_PER_PERIOD samples and sequences may be any length.
// Sequence:
//   A sample that closes a segment goes from acceptance to the next ready
//   through accept, states MUL0 to MUL4 on the one shared 24x40 multiplier
//   (four products, two differences), and a finish state. The first sample
//   of a sequence goes from accept straight to the finish state. The result
//   word appears on the cycle after the finish of the last sample.
// Reset:
//   Synchronous rst clears the sums, the phase and the result valid flag; the
//   coefficient table is constant and needs no fill.
// Stalls:
//   The result word is held until taken. The next sequence is accepted
//   meanwhile; only the finish of its last sample waits for the word slot.
// ----------------------------------------------------------------------------
module piecewise_linear_fourier_bin_top import plfb_pkg::*; #(
  parameter int SAMPLES_PER_PERIOD = 64
) (
  input logic         clk,
  input logic         rst,
  plfb_in_if.sink     sample_ch,
  plfb_out_if.source  coef_ch
);

  localparam int PHASE_W = $clog2(SAMPLES_PER_PERIOD);
  localparam int PROD_W  = SAMPLE_W + COEF_W;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int FRAC_W  = 40;   // coefficient fraction dropped from each term
  localparam int TERM_W  = DIFF_W - FRAC_W;

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SAMPLES_PER_PERIOD - 1);
  localparam logic signed [DIFF_W:0] RND_POS = (DIFF_W+1)'(1) <<< (FRAC_W - 1);
  localparam logic signed [DIFF_W:0] RND_NEG = RND_POS - (DIFF_W+1)'(1);
  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_MUL3 = 3'd4;
  localparam logic [2:0] S_MUL4 = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [TERM_W-1:0] term_t;

  // Drop the fraction, rounding half away from zero.
  function automatic term_t round_term(input diff_t x);
    logic signed [DIFF_W:0] t;
    t = (DIFF_W+1)'(x) + (x[DIFF_W-1] ? RND_NEG : RND_POS);
    return t[FRAC_W +: TERM_W];
  endfunction

  function automatic sum_t sat_add(input sum_t a, input term_t d);
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(d);
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic               started;     // a sample of this sequence is held
  logic [PHASE_W-1:0] phase;       // phase of the held sample
  sample_t            y0;          // held (older) sample
  sample_t            y;           // sample being worked on
  logic               last_q;
  logic               seg;         // this sample closes a segment
  sum_t               sum_real;
  sum_t               sum_imag;
  logic               out_valid;
  sum_t               out_real;
  sum_t               out_imag;

  coef_set_t          coefs;
  sample_t            mul_a;
  coef_t              mul_b;
  prod_t              prod;
  prod_t              acc;
  diff_t              diff;
  sum_t               imag_fin;

  logic               accept;
  logic               can_finish;

  assign sample_ch.ready = (state == S_IDLE);
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign can_finish      = !last_q || !out_valid || coef_ch.ready;

  assign coef_ch.valid     = out_valid;
  assign coef_ch.coef_real = out_real;
  assign coef_ch.coef_imag = out_imag;

  // Look up the row for the held phase as the sample is taken.
  plfb_coef_rom #(
    .SAMPLES_PER_PERIOD(SAMPLES_PER_PERIOD)
  ) u_rom (
    .clk     (clk),
    .rd_en   (accept),
    .addr    (phase),
    .rd_data (coefs)
  );

  // Steer the shared multiplier: newer sample on k1 weights, older on k0.
  always_comb begin
    case (state)
      S_MUL0: begin
        mul_a = y;
        mul_b = coefs.re_k1;
      end
      S_MUL1: begin
        mul_a = y0;
        mul_b = coefs.re_k0;
      end
      S_MUL2: begin
        mul_a = y;
        mul_b = coefs.im_k1;
      end
      S_MUL3: begin
        mul_a = y0;
        mul_b = coefs.im_k0;
      end
      default: begin
        mul_a = y;
        mul_b = coefs.re_k1;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_IDLE: state_next = accept ? (started ? S_MUL0 : S_FIN) : S_IDLE;
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_MUL4;
      S_MUL4: state_next = S_FIN;
      S_FIN:  state_next = can_finish ? S_IDLE : S_FIN;
      default: state_next = S_IDLE;
    endcase
  end

  assign imag_fin = seg ? sat_add(sum_imag, round_term(diff)) : sum_imag;

  // Datapath: product, partial and difference registers
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (accept) begin
      y      <= sample_ch.sample;
      last_q <= sample_ch.last_sample;
      seg    <= started;
    end
    if (state == S_MUL1 || state == S_MUL3) begin
      acc <= prod;
    end
    if (state == S_MUL2 || state == S_MUL4) begin
      diff <= DIFF_W'(acc) - DIFF_W'(prod);
    end
    if (state == S_FIN && can_finish && last_q) begin
      out_real <= sum_real;
      out_imag <= imag_fin;
    end
  end

  // Control and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      phase     <= '0;
      y0        <= '0;
      sum_real  <= '0;
      sum_imag  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (coef_ch.valid && coef_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_MUL3) begin
        sum_real <= sat_add(sum_real, round_term(diff));
      end
      if (state == S_FIN && can_finish) begin
        if (last_q) begin
          // Emit the word and start a fresh sequence.
          out_valid <= 1'b1;
          started   <= 1'b0;
          phase     <= '0;
          y0        <= '0;
          sum_real  <= '0;
          sum_imag  <= '0;
        end else begin
          started  <= 1'b1;
          y0       <= y;
          sum_imag <= imag_fin;
          if (seg) begin
            phase <= (phase == PHASE_LAST) ? '0 : phase + PHASE_W'(1);
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/plfb_coef_rom.sv
// ----------------------------------------------------------------------------
// plfb_coef_rom
// Per-phase segment coefficient table, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module plfb_coef_rom import plfb_pkg::*; #(
  parameter int SAMPLES_PER_PERIOD = 64,
  localparam int ADDR_W = $clog2(SAMPLES_PER_PERIOD)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  output coef_set_t         rd_data
);

  localparam int          NTERMS      = 28;
  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] INT64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] N64         = 64'(SAMPLES_PER_PERIOD);

  typedef struct packed {
    longint u;
    longint w;
    longint v;
    longint b;
  } series_t;

  typedef struct packed {
    longint s;
    longint c;
  } trig_t;

  // Q62 product, rounded half up.
  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << 61);
    return p[125:62];
  endfunction

  function automatic logic [63:0] mag(input longint a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint smul(input longint a, input longint b);
    logic        neg;
    logic [63:0] m;
    neg = (a < 0) != (b < 0);
    m = mulq(mag(a), mag(b));
    if (m > INT64_MAX) begin
      m = INT64_MAX;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Q62 to Q40, half away from zero.
  function automatic longint round_q40(input longint x);
    logic [63:0] m;
    m = (mag(x) + (64'd1 << 21)) >> 22;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Truncating quotient by shift and subtract; table build time only.
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Signed quotient by a positive divisor, truncated toward zero.
  function automatic longint sdiv(input longint a, input logic [63:0] d);
    logic [63:0] m;
    m = udiv(mag(a), d);
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  localparam logic [63:0] ANG_STEP = udiv(HALF_PI_Q62, N64);
  localparam logic [63:0] ANG_REM  = HALF_PI_Q62 - ANG_STEP * N64;

  // (pi/2) * num / N in Q62.
  function automatic logic [63:0] angle(input logic [63:0] num);
    return ANG_STEP * num + udiv(ANG_REM * num, N64);
  endfunction

  // Sine and cosine of 2 pi k / N in Q62, k in 0..N-1.
  function automatic trig_t sincos(input int k);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] p;
    logic        swap;
    longint      sn;
    longint      cs;
    longint      v;
    longint      t;
    trig_t       sc;
    // Fold 4k into a quadrant and a remainder below N.
    q = '0;
    r = 64'd4 * 64'(k);
    for (int i = 0; i < 3; i++) begin
      if (r >= N64) begin
        r = r - N64;
        q = q + 64'd1;
      end
    end
    swap = (64'd2 * r) > N64;
    if (swap) begin
      r = N64 - r;
    end
    x = angle(r);
    p = ONE_Q62;
    sn = 0;
    cs = longint'(p);
    for (int j = 1; j < NTERMS; j++) begin
      p = udiv(mulq(p, x), 64'(j));
      v = longint'(p);
      if (j[0]) begin
        sn = j[1] ? sn - v : sn + v;
      end else begin
        cs = j[1] ? cs - v : cs + v;
      end
    end
    if (swap) begin
      t = sn;
      sn = cs;
      cs = t;
    end
    case (q[1:0])
      2'd0: begin
        sc.s = sn;
        sc.c = cs;
      end
      2'd1: begin
        sc.s = cs;
        sc.c = -sn;
      end
      2'd2: begin
        sc.s = -sn;
        sc.c = -cs;
      end
      default: begin
        sc.s = -cs;
        sc.c = sn;
      end
    endcase
    return sc;
  endfunction

  function automatic series_t series();
    logic [63:0] p [NTERMS];
    logic [63:0] x;
    series_t     sr;
    longint      ve;
    longint      be;
    longint      ue;
    longint      we;
    x = angle(64'd4);
    p[0] = ONE_Q62;
    for (int j = 1; j < NTERMS; j++) begin
      p[j] = udiv(mulq(p[j-1], x), 64'(j));
    end
    sr = '0;
    for (int i = 0; 2 * i + 2 < NTERMS; i++) begin
      ve = longint'(udiv(p[2*i], 64'(2*i + 2)));
      be = longint'(udiv(p[2*i], 64'((2*i + 1) * (2*i + 2))));
      sr.v = i[0] ? sr.v - ve : sr.v + ve;
      sr.b = i[0] ? sr.b - be : sr.b + be;
      if (i >= 1) begin
        ue = longint'(udiv(p[2*i-1], 64'(2*i + 1)));
        we = longint'(udiv(p[2*i-1], 64'((2*i) * (2*i + 1))));
        sr.u = i[0] ? sr.u - ue : sr.u + ue;
        sr.w = i[0] ? sr.w + we : sr.w - we;
      end
    end
    sr.u = sdiv(sr.u, N64);
    sr.w = sdiv(sr.w, N64);
    sr.v = sdiv(sr.v, N64);
    sr.b = sdiv(sr.b, N64);
    return sr;
  endfunction

  function automatic coef_set_t coef_at(input int k, input series_t sr);
    trig_t     sc;
    longint    t;
    coef_set_t e;
    sc = sincos(k);
    t = round_q40(smul(sc.s, sr.u) + smul(sc.c, sr.v));
    e.re_k1 = t[COEF_W-1:0];
    t = round_q40(smul(sc.s, sr.w) - smul(sc.c, sr.b));
    e.re_k0 = t[COEF_W-1:0];
    t = round_q40(smul(sc.s, sr.v) - smul(sc.c, sr.u));
    e.im_k1 = t[COEF_W-1:0];
    t = round_q40(-smul(sc.s, sr.b) - smul(sc.c, sr.w));
    e.im_k0 = t[COEF_W-1:0];
    return e;
  endfunction

  localparam series_t SERIES = series();

  coef_set_t tab [SAMPLES_PER_PERIOD];

  for (genvar gk = 0; gk < SAMPLES_PER_PERIOD; gk++) begin : g_tab
    localparam coef_set_t ENTRY = coef_at(gk, SERIES);
    assign tab[gk] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= tab[addr];
    end
  end

endmodule

// File: hw/rtl/plfb_checker.sv
// ----------------------------------------------------------------------------
// plfb_checker
// Port-level checks on the bin block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plfb_checker import plfb_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input sum_t out_real,
  input sum_t out_imag
);

  // A result word held back by the receiver stays put.
  `PLFB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PLFB_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable({out_real, out_imag}))

  // One sample at a time: ready drops after every accepted word.
  `PLFB_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  // Reset leaves no result word pending.
  `PLFB_ASSERT_SAME(a_reset_empty, clk, $past(rst) && !rst, !out_valid)

endmodule

bind piecewise_linear_fourier_bin_top plfb_checker u_plfb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_ch.valid),
  .in_ready  (sample_ch.ready),
  .out_valid (coef_ch.valid),
  .out_ready (coef_ch.ready),
  .out_real  (coef_ch.coef_real),
  .out_imag  (coef_ch.coef_imag)
);
